[rtl/bad_pkg.sv]
// Shared types, codes and constants for the bus address decoder.
package bad_pkg;

  // Main RAM size in bytes; the mirror mask follows from it.
  localparam int unsigned RAM_BYTES = 2097152;
  localparam logic [20:0] RAM_MASK = 21'(RAM_BYTES - 1);

  // Depth of the queue between the front and back parts.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Physical address windows.
  localparam logic [31:0] IO_BASE         = 32'h1F80_1000;
  localparam logic [31:0] IO_END          = 32'h1F80_3000;
  localparam logic [31:0] BIOS_BASE       = 32'h1FC0_0000;
  localparam logic [31:0] BIOS_END        = 32'h1FC8_0000;
  localparam logic [31:0] SCRATCH_BASE    = 32'h1F80_0000;
  localparam logic [31:0] SCRATCH_END     = 32'h1F80_0400;
  localparam logic [31:0] RAM_MIRROR_END  = 32'h0080_0000;
  localparam logic [31:0] EXP1_BASE       = 32'h1F00_0000;
  localparam logic [31:0] POST_ADDR       = 32'h1F80_2041;
  localparam logic [31:0] CACHE_CTRL_ADDR = 32'hFFFE_0130;

  // Number of memory-control registers.
  localparam int unsigned MCTL_WORDS = 9;

  // Command codes.
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Size codes.
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;
  localparam logic [1:0] SZ_BAD  = 2'd3;

  // Target codes.
  localparam logic [3:0] TGT_LOCAL   = 4'd0;
  localparam logic [3:0] TGT_RAM     = 4'd1;
  localparam logic [3:0] TGT_BIOS    = 4'd2;
  localparam logic [3:0] TGT_SCRATCH = 4'd3;
  localparam logic [3:0] TGT_SIO     = 4'd4;
  localparam logic [3:0] TGT_CD      = 4'd5;
  localparam logic [3:0] TGT_IRQ     = 4'd6;
  localparam logic [3:0] TGT_TIMERS  = 4'd7;
  localparam logic [3:0] TGT_DMA     = 4'd8;
  localparam logic [3:0] TGT_GPU     = 4'd9;
  localparam logic [3:0] TGT_SPU     = 4'd10;

  // How the back part expands one queued access into sub-accesses.
  typedef enum logic [1:0] {
    SPLIT_NONE = 2'd0,
    SPLIT_CD   = 2'd1,
    SPLIT_SPU  = 2'd2
  } split_t;

  // One CPU bus access.
  typedef struct packed {
    logic        command;
    logic [1:0]  access_size;
    logic [31:0] address;
    logic [31:0] write_value;
  } in_word_t;

  // One device sub-access.
  typedef struct packed {
    logic [3:0]  target;
    logic [20:0] unit_offset;
    logic [1:0]  sub_size;
    logic [31:0] sub_write_value;
    logic [1:0]  byte_lane;
    logic [31:0] local_data;
    logic        unhandled;
    logic        last;
  } out_word_t;

  // A classified access as it waits in the queue.
  typedef struct packed {
    logic [3:0]  target;
    logic [20:0] unit_offset;
    logic [1:0]  sub_size;
    logic [31:0] sub_write_value;
    logic [31:0] local_data;
    logic        unhandled;
    split_t      split;
    logic [1:0]  last_beat;
  } desc_t;

endpackage

[rtl/bad_front.sv]
// Front part: classifies each bus access and owns the decoder's local registers.
module bad_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bad_pkg::in_word_t in_word,
  output bad_pkg::desc_t    desc
);

  logic [31:0] mctl_r [bad_pkg::MCTL_WORDS];
  logic [31:0] ramsz_r;
  logic [31:0] cache_r;
  logic [7:0]  post_r;

  logic        wr;
  logic [1:0]  size;
  logic [31:0] phys;
  logic [31:0] io_full;
  logic [12:0] io;
  logic [31:0] wv_m;
  logic [31:0] sv;
  logic [3:0]  mctl_idx;
  logic        mctl_we;
  logic        ramsz_we;
  logic        cache_we;
  logic        post_we;

  // Segment masking, write data trimming and the I/O window offset.
  always_comb begin
    wr   = (in_word.command == bad_pkg::CMD_WRITE);
    size = in_word.access_size;
    unique case (in_word.address[31:29])
      3'd4:    phys = in_word.address & 32'h7FFF_FFFF;
      3'd5:    phys = in_word.address & 32'h1FFF_FFFF;
      default: phys = in_word.address;
    endcase
    unique case (size)
      bad_pkg::SZ_BYTE: wv_m = {24'd0, in_word.write_value[7:0]};
      bad_pkg::SZ_HALF: wv_m = {16'd0, in_word.write_value[15:0]};
      default:          wv_m = in_word.write_value;
    endcase
    sv       = wr ? wv_m : 32'd0;
    io_full  = phys - bad_pkg::IO_BASE;
    io       = io_full[12:0];
    mctl_idx = io[5:2];
  end

  // Window decode, in priority order.
  always_comb begin
    desc.target          = bad_pkg::TGT_LOCAL;
    desc.unit_offset     = '0;
    desc.sub_size        = bad_pkg::SZ_BYTE;
    desc.sub_write_value = '0;
    desc.local_data      = '0;
    desc.unhandled       = 1'b1;
    desc.split           = bad_pkg::SPLIT_NONE;
    desc.last_beat       = 2'd0;
    mctl_we  = 1'b0;
    ramsz_we = 1'b0;
    cache_we = 1'b0;
    post_we  = 1'b0;

    if (size == bad_pkg::SZ_BAD) begin
      desc.unhandled = 1'b1;
    end else if (phys < bad_pkg::RAM_MIRROR_END) begin
      desc.unhandled       = 1'b0;
      desc.target          = bad_pkg::TGT_RAM;
      desc.unit_offset     = phys[20:0] & bad_pkg::RAM_MASK;
      desc.sub_size        = size;
      desc.sub_write_value = sv;
    end else if (phys >= bad_pkg::BIOS_BASE && phys < bad_pkg::BIOS_END) begin
      // BIOS is read-only; writes fall through as unhandled.
      if (!wr) begin
        desc.unhandled   = 1'b0;
        desc.target      = bad_pkg::TGT_BIOS;
        desc.unit_offset = 21'(phys - bad_pkg::BIOS_BASE);
        desc.sub_size    = size;
      end
    end else if (phys >= bad_pkg::SCRATCH_BASE && phys < bad_pkg::SCRATCH_END) begin
      desc.unhandled       = 1'b0;
      desc.target          = bad_pkg::TGT_SCRATCH;
      desc.unit_offset     = 21'(phys - bad_pkg::SCRATCH_BASE);
      desc.sub_size        = size;
      desc.sub_write_value = sv;
    end else if (phys >= bad_pkg::IO_BASE && phys < bad_pkg::IO_END) begin
      desc.unhandled       = 1'b0;
      desc.sub_size        = size;
      desc.sub_write_value = sv;
      if (size == bad_pkg::SZ_WORD && io < 13'h024) begin
        // Memory-control registers.
        desc.target          = bad_pkg::TGT_LOCAL;
        desc.sub_write_value = '0;
        desc.local_data      = wr ? 32'd0 : mctl_r[mctl_idx];
        mctl_we              = wr;
      end else if (size == bad_pkg::SZ_WORD && io == 13'h060) begin
        desc.target          = bad_pkg::TGT_LOCAL;
        desc.sub_write_value = '0;
        desc.local_data      = wr ? 32'd0 : ramsz_r;
        ramsz_we             = wr;
      end else if (size != bad_pkg::SZ_BYTE && io >= 13'h070 && io < 13'h078) begin
        desc.target      = bad_pkg::TGT_IRQ;
        desc.unit_offset = 21'(io - 13'h070);
      end else if (size == bad_pkg::SZ_WORD && io >= 13'h080 && io < 13'h100) begin
        desc.target      = bad_pkg::TGT_DMA;
        desc.unit_offset = 21'(io - 13'h080);
      end else if (size != bad_pkg::SZ_BYTE && io >= 13'h100 && io < 13'h130) begin
        desc.target      = bad_pkg::TGT_TIMERS;
        desc.unit_offset = 21'(io - 13'h100);
      end else if (io >= 13'h040 && io < 13'h050) begin
        desc.target      = bad_pkg::TGT_SIO;
        desc.unit_offset = 21'(io - 13'h040);
      end else if (size == bad_pkg::SZ_WORD && (io == 13'h810 || io == 13'h814)) begin
        desc.target      = bad_pkg::TGT_GPU;
        desc.unit_offset = 21'(io - 13'h810);
      end else if (io >= 13'h800 && io < 13'h804) begin
        // CD: one byte access per byte of the access.
        desc.target      = bad_pkg::TGT_CD;
        desc.unit_offset = 21'(io - 13'h800);
        desc.sub_size    = bad_pkg::SZ_BYTE;
        desc.split       = bad_pkg::SPLIT_CD;
        unique case (size)
          bad_pkg::SZ_BYTE: desc.last_beat = 2'd0;
          bad_pkg::SZ_HALF: desc.last_beat = 2'd1;
          default:          desc.last_beat = 2'd3;
        endcase
      end else if (size != bad_pkg::SZ_BYTE && io >= 13'hC00 && io < 13'h1000) begin
        // Sound unit: word accesses become two halfword accesses.
        desc.target      = bad_pkg::TGT_SPU;
        desc.unit_offset = 21'(io - 13'hC00);
        desc.sub_size    = bad_pkg::SZ_HALF;
        if (size == bad_pkg::SZ_WORD) begin
          desc.split     = bad_pkg::SPLIT_SPU;
          desc.last_beat = 2'd1;
        end
      end else if (size == bad_pkg::SZ_BYTE && phys == bad_pkg::POST_ADDR) begin
        desc.target          = bad_pkg::TGT_LOCAL;
        desc.sub_write_value = '0;
        desc.local_data      = wr ? 32'd0 : {24'd0, post_r};
        post_we              = wr;
      end else if (size == bad_pkg::SZ_BYTE && io >= 13'h1000) begin
        // Expansion 2 open bus.
        desc.target          = bad_pkg::TGT_LOCAL;
        desc.sub_write_value = '0;
        desc.local_data      = wr ? 32'd0 : 32'h0000_00FF;
      end else begin
        desc.unhandled       = 1'b1;
        desc.sub_size        = bad_pkg::SZ_BYTE;
        desc.sub_write_value = '0;
      end
    end else if (phys >= bad_pkg::EXP1_BASE && phys < bad_pkg::SCRATCH_BASE) begin
      // Expansion 1 open bus; halfword accesses are not decoded.
      if (size != bad_pkg::SZ_HALF) begin
        desc.unhandled  = 1'b0;
        desc.sub_size   = size;
        if (wr) begin
          desc.local_data = 32'd0;
        end else if (size == bad_pkg::SZ_BYTE) begin
          desc.local_data = 32'h0000_00FF;
        end else begin
          desc.local_data = 32'hFFFF_FFFF;
        end
      end
    end else if (size == bad_pkg::SZ_WORD && in_word.address == bad_pkg::CACHE_CTRL_ADDR) begin
      desc.unhandled  = 1'b0;
      desc.sub_size   = bad_pkg::SZ_WORD;
      desc.local_data = wr ? 32'd0 : cache_r;
      cache_we        = wr;
    end
  end

  // Local register updates, taken in access order as words enter the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bad_pkg::MCTL_WORDS; i++) begin
        mctl_r[i] <= '0;
      end
      ramsz_r <= '0;
      cache_r <= '0;
      post_r  <= '0;
    end else if (push) begin
      if (mctl_we) begin
        mctl_r[mctl_idx] <= wv_m;
      end
      if (ramsz_we) begin
        ramsz_r <= wv_m;
      end
      if (cache_we) begin
        cache_r <= wv_m;
      end
      if (post_we) begin
        post_r <= wv_m[7:0];
      end
    end
  end

endmodule

[rtl/bad_queue.sv]
// Short queue of classified accesses between the front and back parts.
module bad_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bad_pkg::desc_t push_desc,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output bad_pkg::desc_t head_desc
);

  bad_pkg::desc_t            q_r [bad_pkg::QDEPTH];
  logic [bad_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [bad_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [bad_pkg::QCNT_W-1:0] count_r;
  logic [bad_pkg::QCNT_W-1:0] count_nxt;

  assign full       = (count_r == bad_pkg::QCNT_W'(bad_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_desc  = q_r[rd_ptr_r];

  // Occupancy follows the push and pop strobes.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == bad_pkg::QPTR_W'(bad_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == bad_pkg::QPTR_W'(bad_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

[rtl/bad_back.sv]
// Back part: expands each queued access into sub-access words on the output.
module bad_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  bad_pkg::desc_t     head_desc,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output bad_pkg::out_word_t out_word
);

  logic [1:0]         beat_r;
  logic [1:0]         beat_nxt;
  logic               out_valid_r;
  bad_pkg::out_word_t out_word_r;
  bad_pkg::out_word_t beat_word;
  logic               load;
  logic               is_last;
  logic [2:0]         cd_sum;
  logic [31:0]        cd_shift;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign load      = head_valid && (!out_valid_r || out_ready);
  assign is_last   = (beat_r == head_desc.last_beat);
  assign pop       = load && is_last;

  // Fields of the current beat.
  always_comb begin
    cd_sum   = {1'b0, head_desc.unit_offset[1:0]} + {1'b0, beat_r};
    cd_shift = head_desc.sub_write_value >> {beat_r, 3'b000};
    beat_word.target          = head_desc.target;
    beat_word.unit_offset     = head_desc.unit_offset;
    beat_word.sub_size        = head_desc.sub_size;
    beat_word.sub_write_value = head_desc.sub_write_value;
    beat_word.byte_lane       = 2'd0;
    beat_word.local_data      = head_desc.local_data;
    beat_word.unhandled       = head_desc.unhandled;
    beat_word.last            = is_last;
    unique case (head_desc.split)
      bad_pkg::SPLIT_CD: begin
        // Byte offsets stop at the last CD register.
        beat_word.unit_offset     = (cd_sum > 3'd3) ? 21'd3 : 21'(cd_sum);
        beat_word.sub_write_value = {24'd0, cd_shift[7:0]};
        beat_word.byte_lane       = beat_r;
      end
      bad_pkg::SPLIT_SPU: begin
        if (beat_r[0]) begin
          beat_word.unit_offset     = head_desc.unit_offset + 21'd2;
          beat_word.sub_write_value = {16'd0, head_desc.sub_write_value[31:16]};
          beat_word.byte_lane       = 2'd2;
        end else begin
          beat_word.sub_write_value = {16'd0, head_desc.sub_write_value[15:0]};
        end
      end
      default: begin
      end
    endcase
  end

  // Beat counter within one access.
  always_comb begin
    beat_nxt = beat_r;
    if (load) begin
      beat_nxt = is_last ? 2'd0 : beat_r + 2'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      beat_r <= beat_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word_r <= beat_word;
    end
  end

endmodule

[rtl/bus_address_decoder.sv]
// Top level of the bus address decoder: front, queue and back.
//
//   channel | direction | handshake          | word
//   in      | input     | in_valid/in_ready  | in_word   (bad_pkg::in_word_t)
//   out     | output    | out_valid/out_ready| out_word  (bad_pkg::out_word_t)
//
// The front takes one access per cycle whenever the four-entry queue has room.
// The back sends one sub-access word per cycle unless the output stalls: one word
// for most accesses, two for word accesses to the sound unit and up to four for CD
// accesses. Accesses are held in the queue, and words in the output register.
// Reset is synchronous; it empties the queue and the output and clears the
// local registers.
// An output stall holds the output register; the queue keeps taking accesses
// until it fills, after which in_ready drops.
module bus_address_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bad_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output bad_pkg::out_word_t out_word
);

  logic           q_full;
  logic           push;
  logic           pop;
  logic           head_valid;
  bad_pkg::desc_t front_desc;
  bad_pkg::desc_t head_desc;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  bad_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_word (in_word),
    .desc    (front_desc)
  );

  bad_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (front_desc),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  bad_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word)
  );

endmodule

[rtl/bad_checker.sv]
// Port-level checks for the bus address decoder, bound to the top level.
module bad_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input bad_pkg::out_word_t out_word
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  // An unhandled access is a single local word.
  a_unh_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.unhandled |->
      out_word.last && out_word.target == bad_pkg::TGT_LOCAL)
    else $error("unhandled word not a single local word");

  // CD sub-accesses are bytes with clamped offsets.
  a_cd_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.target == bad_pkg::TGT_CD |->
      out_word.sub_size == bad_pkg::SZ_BYTE && out_word.unit_offset < 21'd4)
    else $error("bad CD sub-access");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind bus_address_decoder bad_checker u_bad_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);
